### hdl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

   typedef enum logic [1:0] {
      REG_COEF_A       = 2'd0,
      REG_COEF_B       = 2'd1,
      REG_COEF_C       = 2'd2,
      REG_OVERSAMPLING = 2'd3
   } csr_index_type;

   localparam logic [31:0] C_B6_OFFSET = 32'd4000;
   localparam logic [31:0] C_P_MUL1    = 32'd3038;
   localparam logic [31:0] C_P_MUL2    = 32'hFFFF_E343;
   localparam logic [31:0] C_P_OFFSET  = 32'd3791;
   localparam logic [31:0] C_B7_SCALE  = 32'd50000;
   localparam logic [31:0] C_B4_OFFSET = 32'd32768;
   localparam logic [31:0] C_SIGN_BIT  = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] x1;
      logic [23:0] up;
      logic        err;
      logic        neg;
   } div1_side_type;

   typedef struct packed {
      logic [31:0] t;
      logic        err;
      logic        big;
   } div2_side_type;

   function automatic logic [31:0] sx16(input logic [15:0] w);
      sx16 = {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
      asr = 32'($signed(v) >>> s);
   endfunction

endpackage
`default_nettype wire

### hdl/bpc_div.sv
`default_nettype none
module bpc_div #(
   parameter int WIDTH = 32,
   parameter int PW    = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_num,
   input  wire logic [WIDTH-1:0] in_den,
   input  wire logic [PW-1:0]    in_side,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_quo,
   output logic [PW-1:0]         out_side
);

   // restoring division, one quotient bit per stage
   logic [WIDTH-1:0] vld_ff;
   logic [WIDTH-1:0] rem_ff  [WIDTH];
   logic [WIDTH-1:0] num_ff  [WIDTH];
   logic [WIDTH-1:0] den_ff  [WIDTH];
   logic [WIDTH-1:0] quo_ff  [WIDTH];
   logic [PW-1:0]    side_ff [WIDTH];

   for (genvar k = 0; k < WIDTH; k++) begin : g_stage
      logic             p_vld;
      logic [WIDTH-1:0] p_rem, p_num, p_den, p_quo;
      logic [PW-1:0]    p_side;
      logic [WIDTH:0]   shifted, diff;
      logic             ge;
      logic [WIDTH-1:0] rem_in, num_in, quo_in;

      if (k == 0) begin : g_first
         assign p_vld  = in_valid;
         assign p_rem  = '0;
         assign p_num  = in_num;
         assign p_den  = in_den;
         assign p_quo  = '0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[k-1];
         assign p_rem  = rem_ff[k-1];
         assign p_num  = num_ff[k-1];
         assign p_den  = den_ff[k-1];
         assign p_quo  = quo_ff[k-1];
         assign p_side = side_ff[k-1];
      end

      assign shifted = {p_rem, p_num[WIDTH-1]};
      assign diff    = shifted - {1'b0, p_den};
      assign ge      = ~diff[WIDTH];
      assign rem_in  = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      assign num_in  = {p_num[WIDTH-2:0], 1'b0};
      assign quo_in  = {p_quo[WIDTH-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         num_ff[k]  <= num_in;
         den_ff[k]  <= p_den;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= p_side;
      end
   end

   assign out_valid = vld_ff[WIDTH-1];
   assign out_quo   = quo_ff[WIDTH-1];
   assign out_side  = side_ff[WIDTH-1];

endmodule
`default_nettype wire

### hdl/barometric_pressure_compensation.sv
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the two 32-stage pipelined dividers plus 14 arithmetic stages.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-high reset clears all valid bits and the coefficient registers.
`default_nettype none
module barometric_pressure_compensation import bpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_raw_temp,
   input  wire logic [23:0] req_raw_press,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output logic             rsp_valid,
   output logic signed [31:0] rsp_temp_tenths,
   output logic signed [31:0] rsp_press_pa,
   output logic             rsp_div_error
);

   logic [63:0] coef_a_ff, coef_b_ff;
   logic [31:0] coef_c_ff;
   logic [1:0]  oss_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         oss_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_COEF_A:       coef_a_ff <= csr_wdata;
            REG_COEF_B:       coef_b_ff <= csr_wdata;
            REG_COEF_C:       coef_c_ff <= csr_wdata[31:0];
            REG_OVERSAMPLING: oss_ff    <= csr_wdata[1:0];
            default:          ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(coef_a_ff[63:48]);
   assign ac2 = sx16(coef_a_ff[47:32]);
   assign ac3 = sx16(coef_a_ff[31:16]);
   assign ac4 = {16'd0, coef_a_ff[15:0]};
   assign ac5 = {16'd0, coef_b_ff[63:48]};
   assign ac6 = {16'd0, coef_b_ff[47:32]};
   assign b1  = sx16(coef_b_ff[31:16]);
   assign b2  = sx16(coef_b_ff[15:0]);
   assign mc  = sx16(coef_c_ff[31:16]);
   assign md  = sx16(coef_c_ff[15:0]);

   // stage 0: capture, align pressure
   logic        s0_vld_ff;
   logic [15:0] s0_ut_ff;
   logic [23:0] s0_up_ff;
   logic [3:0]  up_shift;
   assign up_shift = 4'd8 - {2'd0, oss_ff};

   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else       s0_vld_ff <= start && !busy;
   end
   always_ff @(posedge clock) begin
      s0_ut_ff <= req_raw_temp;
      s0_up_ff <= req_raw_press >> up_shift;
   end

   // stage 1: ut - ac6
   logic        s1_vld_ff;
   logic [31:0] s1_d_ff;
   logic [23:0] s1_up_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= s0_vld_ff;
   end
   always_ff @(posedge clock) begin
      s1_d_ff  <= {16'd0, s0_ut_ff} - ac6;
      s1_up_ff <= s0_up_ff;
   end

   // stage 2: x1
   logic        s2_vld_ff;
   logic [31:0] s2_x1_ff;
   logic [23:0] s2_up_ff;
   logic [31:0] s2_prod;
   assign s2_prod = s1_d_ff * ac5;
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      s2_x1_ff <= asr(s2_prod, 5'd15);
      s2_up_ff <= s1_up_ff;
   end

   // stage 3: divisor, magnitudes for signed division
   logic          s3_vld_ff;
   logic [31:0]   s3_ma_ff, s3_mb_ff;
   div1_side_type s3_side_ff, s3_side_in;
   logic [31:0]   den, mcs;
   assign den = s2_x1_ff + md;
   assign mcs = mc << 11;
   always_comb begin
      s3_side_in.x1  = s2_x1_ff;
      s3_side_in.up  = s2_up_ff;
      s3_side_in.err = (den == '0);
      s3_side_in.neg = mcs[31] ^ den[31];
   end
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
   end
   always_ff @(posedge clock) begin
      s3_ma_ff   <= mcs[31] ? (32'd0 - mcs) : mcs;
      s3_mb_ff   <= den[31] ? (32'd0 - den) : den;
      s3_side_ff <= s3_side_in;
   end

   logic          d1_vld;
   logic [31:0]   d1_quo;
   logic [$bits(div1_side_type)-1:0] d1_side_raw;
   div1_side_type d1_side;
   bpc_div #(.WIDTH(32), .PW($bits(div1_side_type))) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .in_num    (s3_ma_ff),
      .in_den    (s3_mb_ff),
      .in_side   (s3_side_ff),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_side  (d1_side_raw)
   );
   assign d1_side = div1_side_type'(d1_side_raw);

   // stage 4: b5, t, b6
   logic        s4_vld_ff, s4_err_ff;
   logic [31:0] s4_t_ff, s4_b6_ff;
   logic [23:0] s4_up_ff;
   logic [31:0] x2t, b5, b5r;
   assign x2t = d1_side.neg ? (32'd0 - d1_quo) : d1_quo;
   assign b5  = d1_side.x1 + x2t;
   assign b5r = b5 + 32'd8;
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= d1_vld;
   end
   always_ff @(posedge clock) begin
      s4_err_ff <= d1_side.err;
      s4_t_ff   <= asr(b5r, 5'd4);
      s4_b6_ff  <= b5 - C_B6_OFFSET;
      s4_up_ff  <= d1_side.up;
   end

   // stage 5: products on b6
   logic        s5_vld_ff, s5_err_ff;
   logic [31:0] s5_t_ff, s5_sq_ff, s5_x2a_ff, s5_x1c_ff;
   logic [23:0] s5_up_ff;
   logic [31:0] m_sq, m_a2, m_a3;
   assign m_sq = s4_b6_ff * s4_b6_ff;
   assign m_a2 = ac2 * s4_b6_ff;
   assign m_a3 = ac3 * s4_b6_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= s4_vld_ff;
   end
   always_ff @(posedge clock) begin
      s5_err_ff <= s4_err_ff;
      s5_t_ff   <= s4_t_ff;
      s5_up_ff  <= s4_up_ff;
      s5_sq_ff  <= asr(m_sq, 5'd12);
      s5_x2a_ff <= asr(m_a2, 5'd11);
      s5_x1c_ff <= asr(m_a3, 5'd13);
   end

   // stage 6: products on sq
   logic        s6_vld_ff, s6_err_ff;
   logic [31:0] s6_t_ff, s6_x1b_ff, s6_x2a_ff, s6_x1c_ff, s6_x2c_ff;
   logic [23:0] s6_up_ff;
   logic [31:0] m_b2, m_b1;
   assign m_b2 = b2 * s5_sq_ff;
   assign m_b1 = b1 * s5_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
   end
   always_ff @(posedge clock) begin
      s6_err_ff <= s5_err_ff;
      s6_t_ff   <= s5_t_ff;
      s6_up_ff  <= s5_up_ff;
      s6_x2a_ff <= s5_x2a_ff;
      s6_x1c_ff <= s5_x1c_ff;
      s6_x1b_ff <= asr(m_b2, 5'd11);
      s6_x2c_ff <= asr(m_b1, 5'd16);
   end

   // stage 7: b3 and x3
   logic        s7_vld_ff, s7_err_ff;
   logic [31:0] s7_t_ff, s7_b3_ff, s7_x3_ff;
   logic [23:0] s7_up_ff;
   logic [31:0] x3a, b3v, b3adj, x3s;
   assign x3a   = s6_x1b_ff + s6_x2a_ff;
   assign b3v   = (((ac1 << 2) + x3a) << oss_ff) + 32'd2;
   assign b3adj = b3v[31] ? (b3v + 32'd3) : b3v;
   assign x3s   = s6_x1c_ff + s6_x2c_ff + 32'd2;
   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else       s7_vld_ff <= s6_vld_ff;
   end
   always_ff @(posedge clock) begin
      s7_err_ff <= s6_err_ff;
      s7_t_ff   <= s6_t_ff;
      s7_up_ff  <= s6_up_ff;
      s7_b3_ff  <= asr(b3adj, 5'd2);
      s7_x3_ff  <= asr(x3s, 5'd2);
   end

   // stage 8: b4 and up - b3
   logic        s8_vld_ff, s8_err_ff;
   logic [31:0] s8_t_ff, s8_b4_ff, s8_d7_ff;
   logic [31:0] m_b4;
   assign m_b4 = ac4 * (s7_x3_ff + C_B4_OFFSET);
   always_ff @(posedge clock) begin
      if (reset) s8_vld_ff <= 1'b0;
      else       s8_vld_ff <= s7_vld_ff;
   end
   always_ff @(posedge clock) begin
      s8_err_ff <= s7_err_ff;
      s8_t_ff   <= s7_t_ff;
      s8_b4_ff  <= m_b4 >> 15;
      s8_d7_ff  <= {8'd0, s7_up_ff} - s7_b3_ff;
   end

   // stage 9: b7, dividend select
   logic          s9_vld_ff;
   logic [31:0]   s9_num_ff, s9_den_ff;
   div2_side_type s9_side_ff, s9_side_in;
   logic [31:0]   b7;
   assign b7 = s8_d7_ff * (C_B7_SCALE >> oss_ff);
   always_comb begin
      s9_side_in.t   = s8_t_ff;
      s9_side_in.err = s8_err_ff || (s8_b4_ff == '0);
      s9_side_in.big = (b7 >= C_SIGN_BIT);
   end
   always_ff @(posedge clock) begin
      if (reset) s9_vld_ff <= 1'b0;
      else       s9_vld_ff <= s8_vld_ff;
   end
   always_ff @(posedge clock) begin
      s9_num_ff  <= s9_side_in.big ? b7 : (b7 << 1);
      s9_den_ff  <= s8_b4_ff;
      s9_side_ff <= s9_side_in;
   end

   logic          d2_vld;
   logic [31:0]   d2_quo;
   logic [$bits(div2_side_type)-1:0] d2_side_raw;
   div2_side_type d2_side;
   bpc_div #(.WIDTH(32), .PW($bits(div2_side_type))) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s9_vld_ff),
      .in_num    (s9_num_ff),
      .in_den    (s9_den_ff),
      .in_side   (s9_side_ff),
      .out_valid (d2_vld),
      .out_quo   (d2_quo),
      .out_side  (d2_side_raw)
   );
   assign d2_side = div2_side_type'(d2_side_raw);

   // stage 10: p
   logic        s10_vld_ff, s10_err_ff;
   logic [31:0] s10_t_ff, s10_p_ff;
   always_ff @(posedge clock) begin
      if (reset) s10_vld_ff <= 1'b0;
      else       s10_vld_ff <= d2_vld;
   end
   always_ff @(posedge clock) begin
      s10_err_ff <= d2_side.err;
      s10_t_ff   <= d2_side.t;
      s10_p_ff   <= d2_side.big ? (d2_quo << 1) : d2_quo;
   end

   // stage 11: square and linear term
   logic        s11_vld_ff, s11_err_ff;
   logic [31:0] s11_t_ff, s11_p_ff, s11_sq_ff, s11_x2_ff;
   logic [31:0] p8, m_lin;
   assign p8    = asr(s10_p_ff, 5'd8);
   assign m_lin = C_P_MUL2 * s10_p_ff;
   always_ff @(posedge clock) begin
      if (reset) s11_vld_ff <= 1'b0;
      else       s11_vld_ff <= s10_vld_ff;
   end
   always_ff @(posedge clock) begin
      s11_err_ff <= s10_err_ff;
      s11_t_ff   <= s10_t_ff;
      s11_p_ff   <= s10_p_ff;
      s11_sq_ff  <= p8 * p8;
      s11_x2_ff  <= asr(m_lin, 5'd16);
   end

   // stage 12: scale square
   logic        s12_vld_ff, s12_err_ff;
   logic [31:0] s12_t_ff, s12_p_ff, s12_x1_ff, s12_x2_ff;
   logic [31:0] m_q;
   assign m_q = s11_sq_ff * C_P_MUL1;
   always_ff @(posedge clock) begin
      if (reset) s12_vld_ff <= 1'b0;
      else       s12_vld_ff <= s11_vld_ff;
   end
   always_ff @(posedge clock) begin
      s12_err_ff <= s11_err_ff;
      s12_t_ff   <= s11_t_ff;
      s12_p_ff   <= s11_p_ff;
      s12_x1_ff  <= asr(m_q, 5'd16);
      s12_x2_ff  <= s11_x2_ff;
   end

   // output register
   logic        out_vld_ff, out_err_ff;
   logic [31:0] out_t_ff, out_p_ff;
   logic [31:0] corr, p_fin;
   assign corr  = s12_x1_ff + s12_x2_ff + C_P_OFFSET;
   assign p_fin = s12_p_ff + asr(corr, 5'd4);
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= s12_vld_ff;
   end
   always_ff @(posedge clock) begin
      out_err_ff <= s12_err_ff;
      out_t_ff   <= s12_err_ff ? '0 : s12_t_ff;
      out_p_ff   <= s12_err_ff ? '0 : p_fin;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_div_error   = out_err_ff;
   assign rsp_temp_tenths = $signed(out_t_ff);
   assign rsp_press_pa    = $signed(out_p_ff);

endmodule
`default_nettype wire

### hdl/bpc_checker.sv
`default_nettype none
module bpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        csr_ready,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_temp_tenths,
   input wire logic [31:0] rsp_press_pa,
   input wire logic        rsp_div_error
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port not ready");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (rsp_temp_tenths == '0 && rsp_press_pa == '0))
      else $error("error transaction carries nonzero results");

   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .csr_ready       (csr_ready),
   .rsp_valid       (rsp_valid),
   .rsp_temp_tenths (rsp_temp_tenths),
   .rsp_press_pa    (rsp_press_pa),
   .rsp_div_error   (rsp_div_error)
);
`default_nettype wire

### test/testbench.sv
`default_nettype none
module testbench import bpc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] ut;
      logic [23:0] up;
   } reading_type;

   typedef struct packed {
      logic signed [31:0] temp;
      logic signed [31:0] press;
      logic               err;
   } compensated_type;

   localparam logic [63:0] DS_COEF_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] DS_COEF_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
   localparam logic [31:0] DS_COEF_C = {-16'sd8711, 16'sd2868};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_raw_temp = '0;
   logic [23:0] req_raw_press = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_temp_tenths;
   logic signed [31:0] rsp_press_pa;
   logic        rsp_div_error;

   logic [63:0] cal_a = '0;
   logic [63:0] cal_b = '0;
   logic [31:0] cal_c = '0;
   logic [1:0]  cal_oss = '0;

   reading_type     readings_pending[$];
   compensated_type readings_expected[$];
   int  gap_left = 0;
   bit  no_gaps = 0;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int  failures = 0;

   barometric_pressure_compensation DUT (
      .clock, .reset, .start, .busy, .req_raw_temp, .req_raw_press,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_temp_tenths, .rsp_press_pa, .rsp_div_error
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] shr_arith(input logic [31:0] v, input int s);
      shr_arith = 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      div_trunc = (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic compensated_type compensate(input reading_type r);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, sq, p, t, den;
      compensated_type res;
      ac1 = {{16{cal_a[63]}}, cal_a[63:48]};
      ac2 = {{16{cal_a[47]}}, cal_a[47:32]};
      ac3 = {{16{cal_a[31]}}, cal_a[31:16]};
      ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]};
      ac6 = {16'd0, cal_b[47:32]};
      b1  = {{16{cal_b[31]}}, cal_b[31:16]};
      b2  = {{16{cal_b[15]}}, cal_b[15:0]};
      mc  = {{16{cal_c[31]}}, cal_c[31:16]};
      md  = {{16{cal_c[15]}}, cal_c[15:0]};
      ut  = {16'd0, r.ut};
      up  = {8'd0, r.up} >> (8 - cal_oss);
      res = '{temp: '0, press: '0, err: 1'b1};
      x1 = shr_arith((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return res;
      x2 = div_trunc(mc << 11, den);
      b5 = x1 + x2;
      t = shr_arith(b5 + 32'd8, 4);
      b6 = b5 - C_B6_OFFSET;
      sq = shr_arith(b6 * b6, 12);
      x1 = shr_arith(b2 * sq, 11);
      x2 = shr_arith(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = div_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
      x1 = shr_arith(ac3 * b6, 13);
      x2 = shr_arith(b1 * sq, 16);
      x3 = shr_arith(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + C_B4_OFFSET)) >> 15;
      if (b4 == 0) return res;
      b7 = (up - b3) * (C_B7_SCALE >> cal_oss);
      if (b7 < C_SIGN_BIT) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = shr_arith(p, 8) * shr_arith(p, 8);
      x1 = shr_arith(x1 * C_P_MUL1, 16);
      x2 = shr_arith(C_P_MUL2 * p, 16);
      p = p + shr_arith(x1 + x2 + C_P_OFFSET, 4);
      res = '{temp: t, press: p, err: 1'b0};
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      logic nxt_start;
      reading_type r;
      nxt_start = 1'b0;
      if (reset) begin
         nxt_start = 1'b0;
      end else if (start && !req_taken) begin
         nxt_start = 1'b1;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
      end else if (readings_pending.size() > 0) begin
         r = readings_pending.pop_front();
         req_raw_temp <= r.ut;
         req_raw_press <= r.up;
         nxt_start = 1'b1;
         gap_left = no_gaps ? 0 : $urandom_range(0, 14);
      end
      start <= nxt_start;
   end

   // monitor
   always @(posedge clock) begin
      compensated_type e;
      req_taken <= start && !busy;
      csr_taken <= csr_valid && csr_ready;
      if (!reset && rsp_valid) begin
         if (readings_expected.size() == 0) begin
            $error("result with no transaction outstanding");
            failures++;
         end else begin
            e = readings_expected.pop_front();
            if (rsp_temp_tenths !== e.temp) begin
               $error("temp_tenths expected %0d got %0d", e.temp, rsp_temp_tenths);
               failures++;
            end
            if (rsp_press_pa !== e.press) begin
               $error("press_pa expected %0d got %0d", e.press, rsp_press_pa);
               failures++;
            end
            if (rsp_div_error !== e.err) begin
               $error("div_error expected %0b got %0b", e.err, rsp_div_error);
               failures++;
            end
         end
      end
      if (!reset && start && !busy)
         readings_expected.push_back(compensate('{ut: req_raw_temp, up: req_raw_press}));
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_COEF_A:       cal_a <= csr_wdata;
            REG_COEF_B:       cal_b <= csr_wdata;
            REG_COEF_C:       cal_c <= csr_wdata[31:0];
            REG_OVERSAMPLING: cal_oss <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic calibrate(input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [63:0] o);
      csr_write(REG_COEF_A, a);
      csr_write(REG_COEF_B, b);
      csr_write(REG_COEF_C, c);
      csr_write(REG_OVERSAMPLING, o);
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (readings_pending.size() > 0 || start || readings_expected.size() > 0);
      repeat (5) @(posedge clock);
   endtask

   function automatic reading_type any_reading();
      return '{ut: 16'($urandom), up: 24'($urandom)};
   endfunction

   initial begin
      logic [63:0] a, b, c;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      // reset calibration: zero divisors
      readings_pending.push_back('{ut: 16'd0, up: 24'd0});
      readings_pending.push_back('{ut: 16'hFFFF, up: 24'hFF_FFFF});
      readings_pending.push_back(any_reading());
      drain();
      for (int o = 0; o < 4; o++) begin
         calibrate(DS_COEF_A, DS_COEF_B, 64'(DS_COEF_C), 64'(o));
         readings_pending.push_back('{ut: 16'd0, up: 24'd0});
         readings_pending.push_back('{ut: 16'hFFFF, up: 24'hFF_FFFF});
         readings_pending.push_back('{ut: 16'd27898, up: 24'(23843 << 8)});
         readings_pending.push_back(any_reading());
         drain();
      end
      for (int ph = 0; ph < 8; ph++) begin
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
         c = {$urandom, $urandom};
         case (ph % 5)
            0: begin
               a = DS_COEF_A ^ (a & 64'h00FF_000F_00FF_00FF);
               b = DS_COEF_B ^ (b & 64'h00FF_00FF_00FF_000F);
               c = {c[63:32], DS_COEF_C ^ (c[31:0] & 32'h00FF_00FF)};
            end
            1: ;
            2: begin
               a = '1; b = '1; c = '1;
            end
            3: begin
               b[63:48] = '0;
               c[15:0] = '0;
            end
            default: a[15:0] = '0;
         endcase
         calibrate(a, b, c, {$urandom, $urandom});
         no_gaps = (ph % 3 == 1);
         for (int i = 0; i < 128; i++) readings_pending.push_back(any_reading());
         drain();
      end
      repeat (100) @(posedge clock);
      if (readings_expected.size() != 0) begin
         $error("%0d results never arrived", readings_expected.size());
         failures++;
      end
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
